// File: rtl/fault_event_debounce_store_core_macros.svh
// assertion macros for the fault event store
// used by the top level only, no other dependencies
`ifndef FAULT_EVENT_DEBOUNCE_STORE_CORE_MACROS_SVH
`define FAULT_EVENT_DEBOUNCE_STORE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FEDS_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define FEDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FEDS_ASSERT_ALWAYS(label, clk, rst, expr)
`define FEDS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/feds_pkg.sv
// shared types and constants of the fault event store
// no dependencies
package feds_pkg;

  localparam int NUM_EVENTS = 16;
  localparam int IDW = $clog2(NUM_EVENTS + 1);
  localparam int CMP_W = (IDW > 4) ? IDW : 4;

  localparam logic [7:0] ST_TEST_FAILED = 8'h01;
  localparam logic [7:0] ST_PENDING = 8'h04;
  localparam logic [7:0] ST_CONFIRMED = 8'h08;
  localparam logic [7:0] SAT_MAX = 8'hFF;

  localparam logic [7:0] FAIL_THR_RST = 8'd3;
  localparam logic [7:0] PASS_THR_RST = 8'd3;
  localparam logic [7:0] LEVEL_RST = 8'd1;

  localparam logic [1:0] REG_FAIL_THR = 2'd0;
  localparam logic [1:0] REG_PASS_THR = 2'd1;
  localparam logic [1:0] REG_LEVEL = 2'd2;

  typedef enum logic [2:0] {
    ACT_FAILED  = 3'd0,
    ACT_PASSED  = 3'd1,
    ACT_CLEAR   = 3'd2,
    ACT_READ    = 3'd3,
    ACT_SEARCH  = 3'd4,
    ACT_PRIMARY = 3'd5
  } action_t;

  typedef struct packed {
    logic [7:0] fail_thr;
    logic [7:0] pass_thr;
    logic [7:0] level;
  } cfg_t;

  typedef struct packed {
    logic       active;
    logic       stored;
    logic [7:0] level;
    logic [7:0] occ;
    logic [7:0] status;
  } entry_t;

  typedef struct packed {
    logic       valid;
    action_t    action;
    logic [3:0] ev;
    logic [7:0] mask;
    logic       found;
    logic [4:0] idx;
    entry_t     rec;
    logic       alt_found;
    logic [4:0] alt_idx;
    entry_t     alt_rec;
    logic       any;
  } tok_t;

endpackage

// File: rtl/feds_in_if.sv
// request channel of the fault event store
// no dependencies
interface feds_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [3:0] event_index;
  logic [7:0] match_bits;

  modport source (output valid, action, event_index, match_bits, input ready);
  modport sink (input valid, action, event_index, match_bits, output ready);
endinterface

// File: rtl/feds_out_if.sv
// response channel of the fault event store
// no dependencies
interface feds_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [4:0] entry_index;
  logic       entry_active;
  logic       entry_stored;
  logic [7:0] entry_level;
  logic [7:0] entry_occurrences;
  logic [7:0] entry_status;
  logic       any_active;

  modport source (output valid, found, entry_index, entry_active, entry_stored,
                  entry_level, entry_occurrences, entry_status, any_active,
                  input ready);
  modport sink (input valid, found, entry_index, entry_active, entry_stored,
                entry_level, entry_occurrences, entry_status, any_active,
                output ready);
endinterface

// File: rtl/feds_cell.sv
// one entry of the fault store: debounce state plus one stage of the query chain
// depends on feds_pkg
module feds_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  feds_pkg::cfg_t           cfg,
  input  logic [feds_pkg::CMP_W-1:0] cell_id,
  input  feds_pkg::tok_t           tok_in,
  output feds_pkg::tok_t           tok_out
);

  logic [7:0] fail_run, fail_run_next;
  logic [7:0] pass_run, pass_run_next;
  logic       active, active_next;
  logic       stored, stored_next;
  logic [7:0] severity, severity_next;
  logic [7:0] occ, occ_next;
  logic [7:0] status, status_next;

  logic           hit_ev;
  logic           at_or_after;
  logic [7:0]     fr;
  logic [7:0]     pr;
  feds_pkg::entry_t cur;
  feds_pkg::tok_t   t;

  assign hit_ev = (feds_pkg::CMP_W'(tok_in.ev) == cell_id);
  assign at_or_after = (cell_id >= feds_pkg::CMP_W'(tok_in.ev));
  assign fr = (fail_run < cfg.fail_thr) ? fail_run + 8'd1 : fail_run;
  assign pr = (pass_run < cfg.pass_thr) ? pass_run + 8'd1 : pass_run;

  always_comb begin
    cur.active = active;
    cur.stored = stored;
    cur.level = severity;
    cur.occ = occ;
    cur.status = status;
  end

  always_comb begin
    fail_run_next = fail_run;
    pass_run_next = pass_run;
    active_next = active;
    stored_next = stored;
    severity_next = severity;
    occ_next = occ;
    status_next = status;
    if (tok_in.valid) begin
      unique case (tok_in.action)
        feds_pkg::ACT_FAILED: begin
          if (hit_ev) begin
            pass_run_next = 8'd0;
            fail_run_next = fr;
            severity_next = cfg.level;
            if (fr < cfg.fail_thr) begin
              status_next = feds_pkg::ST_PENDING;
            end else begin
              if (!active && occ < feds_pkg::SAT_MAX) occ_next = occ + 8'd1;
              active_next = 1'b1;
              stored_next = 1'b1;
              status_next = feds_pkg::ST_TEST_FAILED | feds_pkg::ST_PENDING |
                            feds_pkg::ST_CONFIRMED;
            end
          end
        end
        feds_pkg::ACT_PASSED: begin
          if (hit_ev) begin
            fail_run_next = 8'd0;
            pass_run_next = pr;
            if (pr >= cfg.pass_thr) begin
              active_next = 1'b0;
              if ((status & feds_pkg::ST_CONFIRMED) != 8'd0) begin
                stored_next = 1'b1;
                status_next = feds_pkg::ST_CONFIRMED;
              end else begin
                stored_next = 1'b0;
                status_next = 8'd0;
                severity_next = 8'd0;
              end
            end
          end
        end
        feds_pkg::ACT_CLEAR: begin
          fail_run_next = 8'd0;
          pass_run_next = 8'd0;
          active_next = 1'b0;
          stored_next = 1'b0;
          severity_next = 8'd0;
          occ_next = 8'd0;
          status_next = 8'd0;
        end
        default: begin
        end
      endcase
    end
  end

  // query word handed on to the next cell
  always_comb begin
    t = tok_in;
    t.any = tok_in.any | active_next;
    unique case (tok_in.action)
      feds_pkg::ACT_READ: begin
        if (hit_ev) begin
          t.found = 1'b1;
          t.idx = 5'(cell_id);
          t.rec = cur;
        end
      end
      feds_pkg::ACT_SEARCH: begin
        if (!tok_in.found && at_or_after && ((status & tok_in.mask) != 8'd0)) begin
          t.found = 1'b1;
          t.idx = 5'(cell_id + 1'b1);
          t.rec = cur;
        end
      end
      feds_pkg::ACT_PRIMARY: begin
        if (!tok_in.found && active) begin
          t.found = 1'b1;
          t.idx = 5'(cell_id);
          t.rec = cur;
        end
        if (!tok_in.alt_found && stored) begin
          t.alt_found = 1'b1;
          t.alt_idx = 5'(cell_id);
          t.alt_rec = cur;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fail_run <= 8'd0;
      pass_run <= 8'd0;
      active <= 1'b0;
      stored <= 1'b0;
      severity <= 8'd0;
      occ <= 8'd0;
      status <= 8'd0;
      tok_out.valid <= 1'b0;
    end else begin
      fail_run <= fail_run_next;
      pass_run <= pass_run_next;
      active <= active_next;
      stored <= stored_next;
      severity <= severity_next;
      occ <= occ_next;
      status <= status_next;
      tok_out <= t;
    end
  end

endmodule

// File: rtl/fault_event_debounce_store_core.sv
// top level of the debounced fault event store
// depends on feds_pkg, feds_in_if, feds_out_if, feds_cell and the macros header
//
// Each event entry lives in its own cell of a row of NUM_EVENTS cells. An accepted
// request becomes a query word that walks the row one cell per cycle; the cell it
// addresses applies a failed or passed report, every cell clears on a clear, and reads,
// mask searches and primary lookups pick up their entry on the way. An accepted item passes
// launch, the cell row, done_tok and then the response register; one item is in flight at a
// time, and a new request is taken while the previous response still waits. Threshold and
// level registers are written through cfg_we/cfg_index/cfg_data; the user must do so only
// while the block is idle, which the block itself does not enforce.
`include "fault_event_debounce_store_core_macros.svh"
module fault_event_debounce_store_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  feds_in_if.sink           req,
  feds_out_if.source        rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t           state;
  feds_pkg::cfg_t   cfg;
  feds_pkg::tok_t   launch;
  feds_pkg::tok_t   done_tok;
  feds_pkg::tok_t   chain [feds_pkg::NUM_EVENTS];
  feds_pkg::tok_t   start;
  logic [feds_pkg::NUM_EVENTS:0] tok_valid;

  logic             f_found;
  logic [4:0]       f_idx;
  feds_pkg::entry_t f_rec;

  logic             o_found;
  logic [4:0]       o_idx;
  feds_pkg::entry_t o_rec;
  logic             o_any;
  logic             o_valid;

  assign req.ready = (state == S_IDLE);

  always_comb begin
    start = '0;
    start.valid = 1'b1;
    start.action = feds_pkg::action_t'(req.action);
    start.ev = req.event_index;
    start.mask = req.match_bits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fail_thr <= feds_pkg::FAIL_THR_RST;
      cfg.pass_thr <= feds_pkg::PASS_THR_RST;
      cfg.level <= feds_pkg::LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        feds_pkg::REG_FAIL_THR: cfg.fail_thr <= cfg_data;
        feds_pkg::REG_PASS_THR: cfg.pass_thr <= cfg_data;
        feds_pkg::REG_LEVEL:    cfg.level <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < feds_pkg::NUM_EVENTS; g++) begin : g_cell
      feds_pkg::tok_t tin;
      if (g == 0) begin : g_first
        assign tin = launch;
      end else begin : g_rest
        assign tin = chain[g-1];
      end
      feds_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .cfg     (cfg),
        .cell_id (feds_pkg::CMP_W'(g)),
        .tok_in  (tin),
        .tok_out (chain[g])
      );
    end
  endgenerate

  always_comb begin
    tok_valid[0] = launch.valid;
    for (int i = 0; i < feds_pkg::NUM_EVENTS; i++) tok_valid[i+1] = chain[i].valid;
  end

  // response formatting
  always_comb begin
    f_found = 1'b0;
    f_idx = 5'd0;
    f_rec = '0;
    unique case (done_tok.action)
      feds_pkg::ACT_READ: begin
        f_found = done_tok.found;
        f_idx = 5'(done_tok.ev);
        if (done_tok.found) f_rec = done_tok.rec;
      end
      feds_pkg::ACT_SEARCH: begin
        if (done_tok.found) begin
          f_found = 1'b1;
          f_idx = done_tok.idx;
          f_rec = done_tok.rec;
        end else begin
          f_idx = 5'(feds_pkg::NUM_EVENTS);
        end
      end
      feds_pkg::ACT_PRIMARY: begin
        priority if (done_tok.found) begin
          f_found = 1'b1;
          f_idx = done_tok.idx;
          f_rec = done_tok.rec;
        end else if (done_tok.alt_found) begin
          f_found = 1'b1;
          f_idx = done_tok.alt_idx;
          f_rec = done_tok.alt_rec;
        end else begin
          f_found = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      launch.valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (o_valid && rsp.ready && state != S_DONE) o_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            launch <= start;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          launch.valid <= 1'b0;
          if (chain[feds_pkg::NUM_EVENTS-1].valid) begin
            done_tok <= chain[feds_pkg::NUM_EVENTS-1];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!o_valid || rsp.ready) begin
            o_valid <= 1'b1;
            o_found <= f_found;
            o_idx <= f_idx;
            o_rec <= f_rec;
            o_any <= done_tok.any;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid = o_valid;
  assign rsp.found = o_found;
  assign rsp.entry_index = o_idx;
  assign rsp.entry_active = o_rec.active;
  assign rsp.entry_stored = o_rec.stored;
  assign rsp.entry_level = o_rec.level;
  assign rsp.entry_occurrences = o_rec.occ;
  assign rsp.entry_status = o_rec.status;
  assign rsp.any_active = o_any;

  `FEDS_ASSERT_NEXT(a_launch, clk, rst, req.valid && req.ready, launch.valid)
  `FEDS_ASSERT_ALWAYS(a_one_word, clk, rst, $onehot0(tok_valid))
  `FEDS_ASSERT_ALWAYS(a_idle_empty, clk, rst, !req.ready || (tok_valid == '0))

endmodule

// File: test/tb_fault_event_debounce_store_core.sv
// self-checking testbench for fault_event_debounce_store_core
// depends on feds_pkg, feds_in_if, feds_out_if and the block itself
// a shadow of the entry store predicts every response word; directed and random traffic
module tb_fault_event_debounce_store_core;

  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES = 25;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic       found;
    logic [4:0] idx;
    logic       active;
    logic       stored;
    logic [7:0] level;
    logic [7:0] occ;
    logic [7:0] status;
    logic       any_act;
  } rsp_word_t;

  class store_shadow;
    logic [7:0] fail_thr;
    logic [7:0] pass_thr;
    logic [7:0] level;
    logic [7:0] fail_run [feds_pkg::NUM_EVENTS];
    logic [7:0] pass_run [feds_pkg::NUM_EVENTS];
    logic       active [feds_pkg::NUM_EVENTS];
    logic       stored [feds_pkg::NUM_EVENTS];
    logic [7:0] sev [feds_pkg::NUM_EVENTS];
    logic [7:0] occ [feds_pkg::NUM_EVENTS];
    logic [7:0] status [feds_pkg::NUM_EVENTS];
    rsp_word_t  due [$];

    function new();
      fail_thr = feds_pkg::FAIL_THR_RST;
      pass_thr = feds_pkg::PASS_THR_RST;
      level = feds_pkg::LEVEL_RST;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < feds_pkg::NUM_EVENTS; i++) begin
        fail_run[i] = '0;
        pass_run[i] = '0;
        active[i] = 1'b0;
        stored[i] = 1'b0;
        sev[i] = '0;
        occ[i] = '0;
        status[i] = '0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] v);
      case (idx)
        feds_pkg::REG_FAIL_THR: fail_thr = v;
        feds_pkg::REG_PASS_THR: pass_thr = v;
        feds_pkg::REG_LEVEL: level = v;
        default: ;
      endcase
    endfunction

    function void failed_report(int e);
      pass_run[e] = '0;
      if (fail_run[e] < fail_thr) fail_run[e] = fail_run[e] + 8'd1;
      sev[e] = level;
      if (fail_run[e] < fail_thr) begin
        status[e] = feds_pkg::ST_PENDING;
      end else begin
        if (!active[e] && occ[e] < feds_pkg::SAT_MAX) occ[e] = occ[e] + 8'd1;
        active[e] = 1'b1;
        stored[e] = 1'b1;
        status[e] = feds_pkg::ST_TEST_FAILED | feds_pkg::ST_PENDING |
                    feds_pkg::ST_CONFIRMED;
      end
    endfunction

    function void passed_report(int e);
      fail_run[e] = '0;
      if (pass_run[e] < pass_thr) pass_run[e] = pass_run[e] + 8'd1;
      if (pass_run[e] >= pass_thr) begin
        active[e] = 1'b0;
        if ((status[e] & feds_pkg::ST_CONFIRMED) != 0) begin
          stored[e] = 1'b1;
          status[e] = feds_pkg::ST_CONFIRMED;
        end else begin
          stored[e] = 1'b0;
          status[e] = '0;
          sev[e] = '0;
        end
      end
    endfunction

    function rsp_word_t entry_word(int e, logic [4:0] idx);
      rsp_word_t w;
      w = '0;
      w.found = 1'b1;
      w.idx = idx;
      w.active = active[e];
      w.stored = stored[e];
      w.level = sev[e];
      w.occ = occ[e];
      w.status = status[e];
      return w;
    endfunction

    function void apply_request(logic [2:0] act, logic [3:0] ev, logic [7:0] mask);
      rsp_word_t w;
      logic hit;
      w = '0;
      hit = 1'b0;
      case (act)
        feds_pkg::ACT_FAILED: if (ev < feds_pkg::NUM_EVENTS) failed_report(ev);
        feds_pkg::ACT_PASSED: if (ev < feds_pkg::NUM_EVENTS) passed_report(ev);
        feds_pkg::ACT_CLEAR: wipe();
        feds_pkg::ACT_READ: begin
          w.idx = 5'(ev);
          if (ev < feds_pkg::NUM_EVENTS) w = entry_word(ev, 5'(ev));
        end
        feds_pkg::ACT_SEARCH: begin
          w.idx = 5'(feds_pkg::NUM_EVENTS);
          for (int i = ev; i < feds_pkg::NUM_EVENTS; i++) begin
            if (!hit && (status[i] & mask) != 0) begin
              w = entry_word(i, 5'(i + 1));
              hit = 1'b1;
            end
          end
        end
        feds_pkg::ACT_PRIMARY: begin
          for (int i = 0; i < feds_pkg::NUM_EVENTS; i++) begin
            if (!hit && active[i]) begin
              w = entry_word(i, 5'(i));
              hit = 1'b1;
            end
          end
          for (int i = 0; i < feds_pkg::NUM_EVENTS; i++) begin
            if (!hit && stored[i]) begin
              w = entry_word(i, 5'(i));
              hit = 1'b1;
            end
          end
        end
        default: ;
      endcase
      for (int i = 0; i < feds_pkg::NUM_EVENTS; i++)
        if (active[i]) w.any_act = 1'b1;
      due.push_back(w);
    endfunction

    function int waiting();
      return due.size();
    endfunction

    function string compare_response(rsp_word_t got);
      rsp_word_t want;
      string why;
      want = due.pop_front();
      why = "";
      if (got.found !== want.found)
        why = {why, $sformatf(" found %0h/%0h", want.found, got.found)};
      if (got.idx !== want.idx)
        why = {why, $sformatf(" index %0d/%0d", want.idx, got.idx)};
      if (got.active !== want.active)
        why = {why, $sformatf(" active %0h/%0h", want.active, got.active)};
      if (got.stored !== want.stored)
        why = {why, $sformatf(" stored %0h/%0h", want.stored, got.stored)};
      if (got.level !== want.level)
        why = {why, $sformatf(" level %0h/%0h", want.level, got.level)};
      if (got.occ !== want.occ)
        why = {why, $sformatf(" occurrences %0d/%0d", want.occ, got.occ)};
      if (got.status !== want.status)
        why = {why, $sformatf(" status %0h/%0h", want.status, got.status)};
      if (got.any_act !== want.any_act)
        why = {why, $sformatf(" any_active %0h/%0h", want.any_act, got.any_act)};
      return why;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  feds_in_if req_ch();
  feds_out_if rsp_ch();

  fault_event_debounce_store_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  store_shadow shadow;
  int mismatches = 0;
  int words_sent = 0;
  int words_back = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  task automatic report(input string msg);
    if (mismatches < PRINT_CAP) $display("error at %0t:%s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    rsp_word_t got;
    string why;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.found = rsp_ch.found;
        got.idx = rsp_ch.entry_index;
        got.active = rsp_ch.entry_active;
        got.stored = rsp_ch.entry_stored;
        got.level = rsp_ch.entry_level;
        got.occ = rsp_ch.entry_occurrences;
        got.status = rsp_ch.entry_status;
        got.any_act = rsp_ch.any_active;
        words_back++;
        if (shadow.waiting() == 0) begin
          report(" response word with no request outstanding");
        end else begin
          why = shadow.compare_response(got);
          if (why != "") report(why);
        end
      end
      if (req_ch.valid && req_ch.ready)
        shadow.apply_request(req_ch.action, req_ch.event_index, req_ch.match_bits);
    end
  end

  task automatic send_item(input logic [2:0] act, input logic [3:0] ev, input logic [7:0] mask);
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= act;
    req_ch.event_index <= ev;
    req_ch.match_bits <= mask;
    do @(posedge clk); while (!req_ch.ready);
    words_sent++;
  endtask

  task automatic drain(input int extra);
    req_ch.valid <= 1'b0;
    while (words_back != words_sent) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] f, input logic [7:0] p, input logic [7:0] l,
                           input int src_pct, input int snk_pct);
    drain(SETTLE_CYCLES);
    cfg_we <= 1'b1;
    cfg_index <= feds_pkg::REG_FAIL_THR;
    cfg_data <= f;
    @(posedge clk);
    cfg_index <= feds_pkg::REG_PASS_THR;
    cfg_data <= p;
    @(posedge clk);
    cfg_index <= feds_pkg::REG_LEVEL;
    cfg_data <= l;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow.write_reg(feds_pkg::REG_FAIL_THR, f);
    shadow.write_reg(feds_pkg::REG_PASS_THR, p);
    shadow.write_reg(feds_pkg::REG_LEVEL, l);
    src_idle_pct = src_pct;
    sink_stall_pct = snk_pct;
  endtask

  task automatic random_traffic(input int n);
    int done;
    int pick;
    int burst;
    int thr;
    int r;
    logic [3:0] e;
    logic [2:0] act;
    logic [7:0] m;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      r = ($urandom_range(3) != 0) ? $urandom_range(3) : $urandom_range(15);
      e = r[3:0];
      r = $urandom_range(255);
      m = r[7:0];
      if (pick < 35) begin
        act = $urandom_range(1) ? feds_pkg::ACT_FAILED : feds_pkg::ACT_PASSED;
        thr = (act == feds_pkg::ACT_FAILED) ? shadow.fail_thr : shadow.pass_thr;
        burst = (thr > 6) ? $urandom_range(1, 6) : thr + $urandom_range(0, 2);
        if (burst < 1) burst = 1;
        repeat (burst) begin
          r = $urandom_range(255);
          send_item(act, e, r[7:0]);
        end
        done += burst;
      end else if (pick < 55) begin
        send_item($urandom_range(1) ? feds_pkg::ACT_FAILED : feds_pkg::ACT_PASSED, e, m);
        done++;
      end else if (pick < 65) begin
        r = $urandom_range(15);
        send_item(feds_pkg::ACT_READ, r[3:0], m);
        done++;
      end else if (pick < 77) begin
        r = $urandom_range(15);
        case ($urandom_range(4))
          0: m = '0;
          1: m = feds_pkg::ST_TEST_FAILED;
          2: m = feds_pkg::ST_PENDING;
          3: m = feds_pkg::ST_CONFIRMED;
          default: ;
        endcase
        send_item(feds_pkg::ACT_SEARCH, r[3:0], m);
        done++;
      end else if (pick < 87) begin
        send_item(feds_pkg::ACT_PRIMARY, e, m);
        done++;
      end else if (pick < 90) begin
        send_item(feds_pkg::ACT_CLEAR, e, m);
        done++;
      end else if (pick < 94) begin
        send_item($urandom_range(1) ? ACT_SPARE_LO : ACT_SPARE_HI, e, m);
      end else begin
        r = $urandom_range(7);
        act = r[2:0];
        r = $urandom_range(15);
        send_item(act, r[3:0], m);
        if (act != ACT_SPARE_LO && act != ACT_SPARE_HI) done++;
      end
    end
  endtask

  initial begin
    shadow = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= feds_pkg::REG_FAIL_THR;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.action <= feds_pkg::ACT_FAILED;
    req_ch.event_index <= '0;
    req_ch.match_bits <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store, then pending, confirm, heal with and without a confirmed history
    send_item(feds_pkg::ACT_READ, 4'd0, 8'h00);
    send_item(feds_pkg::ACT_READ, 4'd15, 8'hFF);
    send_item(feds_pkg::ACT_PRIMARY, 4'd7, 8'h00);
    send_item(feds_pkg::ACT_SEARCH, 4'd0, 8'hFF);
    send_item(feds_pkg::ACT_FAILED, 4'd0, 8'h00);
    send_item(feds_pkg::ACT_FAILED, 4'd0, 8'hFF);
    send_item(feds_pkg::ACT_SEARCH, 4'd0, feds_pkg::ST_PENDING);
    send_item(feds_pkg::ACT_FAILED, 4'd0, 8'h00);
    send_item(feds_pkg::ACT_PRIMARY, 4'd0, 8'h00);
    send_item(feds_pkg::ACT_READ, 4'd0, 8'h00);
    send_item(feds_pkg::ACT_FAILED, 4'd15, 8'h00);
    send_item(feds_pkg::ACT_PASSED, 4'd15, 8'h00);
    send_item(feds_pkg::ACT_PASSED, 4'd15, 8'h00);
    send_item(feds_pkg::ACT_PASSED, 4'd15, 8'hFF);
    send_item(feds_pkg::ACT_READ, 4'd15, 8'h00);
    send_item(feds_pkg::ACT_PASSED, 4'd0, 8'h00);
    send_item(feds_pkg::ACT_PASSED, 4'd0, 8'h00);
    send_item(feds_pkg::ACT_PASSED, 4'd0, 8'h00);
    send_item(feds_pkg::ACT_PRIMARY, 4'd0, 8'h00);
    send_item(feds_pkg::ACT_SEARCH, 4'd1, feds_pkg::ST_CONFIRMED);
    send_item(feds_pkg::ACT_SEARCH, 4'd0, 8'h00);
    send_item(ACT_SPARE_LO, 4'd9, 8'hA5);
    send_item(ACT_SPARE_HI, 4'd15, 8'hFF);
    send_item(feds_pkg::ACT_CLEAR, 4'd0, 8'h00);
    send_item(feds_pkg::ACT_READ, 4'd0, 8'h00);

    // zero thresholds: every report confirms or heals, occurrences saturate
    run_phase(8'd0, 8'd0, 8'd255, 0, 0);
    repeat (260) begin
      send_item(feds_pkg::ACT_FAILED, 4'd5, 8'h00);
      send_item(feds_pkg::ACT_PASSED, 4'd5, 8'h00);
    end
    send_item(feds_pkg::ACT_READ, 4'd5, 8'h00);
    random_traffic(160);

    run_phase(8'd1, 8'd2, 8'd0, 68, 0);
    hold_asked++;
    random_traffic(160);

    run_phase(8'd2, 8'd3, 8'($urandom_range(255)), 0, 68);
    random_traffic(80);
    drain(0);
    random_traffic(80);

    // maximum thresholds: long runs saturate the run counters
    run_phase(8'd255, 8'd255, 8'($urandom_range(255)), 21, 21);
    repeat (257) send_item(feds_pkg::ACT_FAILED, 4'd9, 8'($urandom_range(255)));
    send_item(feds_pkg::ACT_READ, 4'd9, 8'h00);
    repeat (257) send_item(feds_pkg::ACT_PASSED, 4'd9, 8'($urandom_range(255)));
    send_item(feds_pkg::ACT_READ, 4'd9, 8'h00);
    random_traffic(160);

    run_phase(8'd3, 8'd1, 8'($urandom_range(255)), 21, 21);
    random_traffic(160);

    run_phase(8'($urandom_range(6)), 8'($urandom_range(6)), 8'd255, 0, 68);
    random_traffic(160);

    drain(SETTLE_CYCLES + 15);
    if (shadow.waiting() != 0)
      report($sformatf(" %0d response words never arrived", shadow.waiting()));
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
